// ===== rtl/ship_rrip_stream_bypass_replacement_assert.svh =====
// Assertion macros used by the checker file of the replacement block.
// Needs nothing else; take it in by `include.
`ifndef SHIP_RRIP_STREAM_BYPASS_REPLACEMENT_ASSERT_SVH
`define SHIP_RRIP_STREAM_BYPASS_REPLACEMENT_ASSERT_SVH

// Clocked property, switched off while reset is asserted.
`define SRRIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define SRRIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/srrip_pkg.sv =====
// Shared types and constants of the SHiP-RRIP replacement block.
// No dependencies.
package srrip_pkg;

  localparam int ADDR_W     = 48;
  localparam int SET_IDX_W  = 11;
  localparam int WAY_IDX_W  = 4;
  localparam int SET_MAX_W  = 16;
  localparam int WAY_MAX_W  = 5;
  localparam int SIG_MAX_W  = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_STREAM_THR = 3'd0;
  localparam logic [1:0]            THR_RESET      = 2'd3;
  localparam logic [1:0]            RRPV_DISTANT   = 2'd3;
  localparam logic [1:0]            RRPV_NEAR      = 2'd0;
  localparam logic [1:0]            REUSE_INIT     = 2'd1;
  localparam logic [1:0]            CNT_MAX        = 2'd3;
  localparam logic [ADDR_W-1:0]     STRIDE_NEAR    = 48'd64;
  localparam logic [ADDR_W-1:0]     STRIDE_FAR     = 48'd128;

  typedef enum logic [1:0] {
    OP_VICTIM,
    OP_UPDATE,
    OP_STREAM
  } cmd_op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    cmd_op_e                op;
    logic [SET_MAX_W-1:0]   set;
    logic [WAY_MAX_W-1:0]   way;
    logic [SIG_MAX_W-1:0]   sig;
    logic                   hit;
    logic [ADDR_W-1:0]      addr;
  } cmd_t;

endpackage

// ===== rtl/srrip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/srrip_cmdq.sv =====
// Two-entry command queue between the front and the back part.
// Depends on srrip_pkg.
module srrip_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srrip_pkg::cmd_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output srrip_pkg::cmd_t  data_o,
  output logic             empty_o
);

  srrip_pkg::cmd_t ent_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = ent_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/srrip_front.sv =====
// Front part: accepts items, folds the set index, forms the signature, classifies.
// Depends on srrip_pkg.
module srrip_front #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int SIG_BITS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               req_type_i,
  input  logic [srrip_pkg::SET_IDX_W-1:0]    set_index_i,
  input  logic [srrip_pkg::WAY_IDX_W-1:0]    way_i,
  input  logic [srrip_pkg::ADDR_W-1:0]       addr_i,
  input  logic [srrip_pkg::ADDR_W-1:0]       pc_i,
  input  logic                               hit_i,
  input  logic                               busy_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output srrip_pkg::cmd_t                    q_data_o
);

  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT+1)'((1 << RECIP_SHIFT) / NUM_SETS);
  localparam int PROD_W = srrip_pkg::SET_IDX_W + RECIP_SHIFT + 1;
  localparam int REM_W  = 28;

  logic                              f1_vld_q, f1_vld_d;
  logic                              f1_req_q, f1_hit_q;
  logic [srrip_pkg::SET_IDX_W-1:0]   f1_set_q, f1_quo_q;
  logic [srrip_pkg::WAY_IDX_W-1:0]   f1_way_q;
  logic [srrip_pkg::ADDR_W-1:0]      f1_addr_q;
  logic [SIG_BITS-1:0]               f1_pcsig_q;
  logic [PROD_W-1:0]                 prod;
  logic                              accept, advance;
  logic [REM_W-1:0]                  qn, rem, rem_fix;
  logic [srrip_pkg::SET_MAX_W-1:0]   set_red;
  logic [SIG_BITS-1:0]               sig;

  assign full    = busy_i || (f1_vld_q && q_full_i);
  assign accept  = push && !full;
  assign advance = f1_vld_q && !q_full_i;
  assign prod    = PROD_W'(set_index_i) * PROD_W'(RECIP);

  // quotient estimate is low by at most one; one correction step
  assign qn      = REM_W'(f1_quo_q) * REM_W'(NUM_SETS);
  assign rem     = REM_W'(f1_set_q) - qn;
  assign rem_fix = (rem >= REM_W'(NUM_SETS)) ? rem - REM_W'(NUM_SETS) : rem;
  assign set_red = rem_fix[srrip_pkg::SET_MAX_W-1:0];
  assign sig     = f1_pcsig_q ^ set_red[SIG_BITS-1:0];

  always_comb begin
    q_data_o      = '0;
    q_data_o.set  = set_red;
    q_data_o.way  = srrip_pkg::WAY_MAX_W'(f1_way_q);
    q_data_o.sig  = srrip_pkg::SIG_MAX_W'(sig);
    q_data_o.hit  = f1_hit_q;
    q_data_o.addr = f1_addr_q;
    if (!f1_req_q) begin
      q_data_o.op = srrip_pkg::OP_VICTIM;
    end else if (32'(f1_way_q) < NUM_WAYS) begin
      q_data_o.op = srrip_pkg::OP_UPDATE;
    end else begin
      q_data_o.op = srrip_pkg::OP_STREAM;
    end
  end

  assign q_push_o = advance;

  always_comb begin
    f1_vld_d = f1_vld_q;
    if (accept) begin
      f1_vld_d = 1'b1;
    end else if (advance) begin
      f1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= f1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_req_q   <= req_type_i;
      f1_hit_q   <= hit_i;
      f1_set_q   <= set_index_i;
      f1_quo_q   <= prod[RECIP_SHIFT +: srrip_pkg::SET_IDX_W];
      f1_way_q   <= way_i;
      f1_addr_q  <= addr_i;
      f1_pcsig_q <= pc_i[SIG_BITS+1:2];
    end
  end

endmodule

// ===== rtl/srrip_back.sv =====
// Back part: read-modify-write of one set's metadata row, result register.
// Depends on srrip_pkg and srrip_ram.
module srrip_back #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int SIG_BITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        thr_i,
  input  logic                              cmd_vld_i,
  input  srrip_pkg::cmd_t                   cmd_i,
  output logic                              cmd_pop_o,
  output logic                              busy_o,
  output logic                              res_vld_o,
  output logic [srrip_pkg::WAY_IDX_W-1:0]   res_way_o,
  input  logic                              res_pop_i
);

  localparam int SET_W   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W   = $clog2(NUM_WAYS);
  localparam int SIG_CNT = 1 << SIG_BITS;
  localparam int SG_LSB  = 2 * NUM_WAYS;
  localparam int RU_LSB  = SG_LSB + NUM_WAYS * SIG_BITS;
  localparam int SC_LSB  = RU_LSB + 2 * SIG_CNT;
  localparam int PA_LSB  = SC_LSB + 2;
  localparam int ROW_W   = PA_LSB + srrip_pkg::ADDR_W;

  srrip_pkg::back_state_e state_q, state_d;
  srrip_pkg::cmd_t        cmd_q;
  logic [SET_W-1:0]       clr_q, clr_d;
  logic                   res_vld_q, res_vld_d;
  logic [srrip_pkg::WAY_IDX_W-1:0] res_way_q;

  logic                   ram_we, ram_re, res_load, exec_go;
  logic [SET_W-1:0]       ram_waddr;
  logic [ROW_W-1:0]       ram_wdata, row, new_row, reset_row;

  logic [1:0]             rr_a [NUM_WAYS];
  logic [1:0]             rr_n [NUM_WAYS];
  logic [SIG_BITS-1:0]    sg_a [NUM_WAYS];
  logic [SIG_BITS-1:0]    sg_n [NUM_WAYS];
  logic [1:0]             ru_a [SIG_CNT];
  logic [1:0]             ru_n [SIG_CNT];
  logic [1:0]             sc, sc_n, mx, add, pred, ins;
  logic [srrip_pkg::ADDR_W-1:0] pa, diff;
  logic                   stride, streaming;
  logic [2:0]             any_lvl;
  logic [WAY_W-1:0]       best, w;
  logic [SIG_BITS-1:0]    old, sig;

  srrip_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cmd_i.set[SET_W-1:0]),
    .rdata_o(row)
  );

  always_comb begin
    reset_row = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      reset_row[2*i +: 2] = srrip_pkg::RRPV_DISTANT;
    end
    for (int i = 0; i < SIG_CNT; i++) begin
      reset_row[RU_LSB + 2*i +: 2] = srrip_pkg::REUSE_INIT;
    end
  end

  // metadata update for the command held in cmd_q
  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      rr_a[i] = row[2*i +: 2];
      sg_a[i] = row[SG_LSB + SIG_BITS*i +: SIG_BITS];
    end
    for (int i = 0; i < SIG_CNT; i++) begin
      ru_a[i] = row[RU_LSB + 2*i +: 2];
    end
    sc   = row[SC_LSB +: 2];
    pa   = row[PA_LSB +: srrip_pkg::ADDR_W];
    w    = cmd_q.way[WAY_W-1:0];
    sig  = cmd_q.sig[SIG_BITS-1:0];
    old  = sg_a[w];
    pred = ru_a[sig];
    ins  = (pred >= 2'd2) ? 2'd1 : ((pred == 2'd1) ? 2'd2 : 2'd3);

    diff   = cmd_q.addr - pa;
    stride = (pa != '0) &&
             (diff == srrip_pkg::STRIDE_NEAR || diff == srrip_pkg::STRIDE_FAR ||
              diff == (srrip_pkg::ADDR_W'(0) - srrip_pkg::STRIDE_NEAR) ||
              diff == (srrip_pkg::ADDR_W'(0) - srrip_pkg::STRIDE_FAR));
    if (stride) begin
      sc_n = (sc != srrip_pkg::CNT_MAX) ? sc + 2'd1 : sc;
    end else begin
      sc_n = (sc != 2'd0) ? sc - 2'd1 : sc;
    end
    streaming = (sc_n >= thr_i);

    any_lvl = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (rr_a[i] != 2'd0) begin
        any_lvl[rr_a[i] - 2'd1] = 1'b1;
      end
    end
    mx = any_lvl[2] ? 2'd3 : (any_lvl[1] ? 2'd2 : (any_lvl[0] ? 2'd1 : 2'd0));
    add = srrip_pkg::RRPV_DISTANT - mx;
    best = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (rr_a[i] == mx) begin
        best = WAY_W'(i);
      end
    end

    rr_n = rr_a;
    sg_n = sg_a;
    ru_n = ru_a;
    case (cmd_q.op)
      srrip_pkg::OP_VICTIM: begin
        for (int i = 0; i < NUM_WAYS; i++) begin
          rr_n[i] = rr_a[i] + add;
        end
      end
      srrip_pkg::OP_UPDATE: begin
        if (streaming) begin
          rr_n[w] = srrip_pkg::RRPV_DISTANT;
          sg_n[w] = sig;
        end else if (cmd_q.hit) begin
          rr_n[w] = srrip_pkg::RRPV_NEAR;
          if (ru_a[old] != srrip_pkg::CNT_MAX) begin
            ru_n[old] = ru_a[old] + 2'd1;
          end
        end else begin
          // penalize the evicted line's signature before it is replaced
          if (ru_a[old] != 2'd0) begin
            ru_n[old] = ru_a[old] - 2'd1;
          end
          rr_n[w] = ins;
          sg_n[w] = sig;
        end
      end
      default: begin
      end
    endcase

    new_row = row;
    for (int i = 0; i < NUM_WAYS; i++) begin
      new_row[2*i +: 2] = rr_n[i];
      new_row[SG_LSB + SIG_BITS*i +: SIG_BITS] = sg_n[i];
    end
    for (int i = 0; i < SIG_CNT; i++) begin
      new_row[RU_LSB + 2*i +: 2] = ru_n[i];
    end
    if (cmd_q.op != srrip_pkg::OP_VICTIM) begin
      new_row[SC_LSB +: 2] = sc_n;
      new_row[PA_LSB +: srrip_pkg::ADDR_W] = cmd_q.addr;
    end
  end

  // a victim waits for the result register to drain
  assign exec_go = (cmd_q.op != srrip_pkg::OP_VICTIM) || !res_vld_q || res_pop_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      srrip_pkg::BK_CLEAR: begin
        if (clr_q == SET_W'(NUM_SETS - 1)) begin
          state_d = srrip_pkg::BK_IDLE;
        end
      end
      srrip_pkg::BK_IDLE: begin
        if (cmd_vld_i) begin
          state_d = srrip_pkg::BK_EXEC;
        end
      end
      srrip_pkg::BK_EXEC: begin
        if (exec_go) begin
          state_d = srrip_pkg::BK_IDLE;
        end
      end
      default: state_d = srrip_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = reset_row;
    res_load  = 1'b0;
    clr_d     = clr_q;
    case (state_q)
      srrip_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      srrip_pkg::BK_IDLE: begin
        cmd_pop_o = cmd_vld_i;
        ram_re    = cmd_vld_i;
      end
      srrip_pkg::BK_EXEC: begin
        if (exec_go) begin
          ram_we    = 1'b1;
          ram_waddr = cmd_q.set[SET_W-1:0];
          ram_wdata = new_row;
          res_load  = (cmd_q.op == srrip_pkg::OP_VICTIM);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (res_pop_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srrip_pkg::BK_CLEAR;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (res_load) begin
      res_way_q <= srrip_pkg::WAY_IDX_W'(best);
    end
  end

  assign busy_o    = (state_q == srrip_pkg::BK_CLEAR);
  assign res_vld_o = res_vld_q;
  assign res_way_o = res_way_q;

endmodule

// ===== rtl/ship_rrip_stream_bypass_replacement.sv =====
// Top level of the SHiP-RRIP replacement block with per-set stream bypass.
// Depends on srrip_pkg, srrip_front, srrip_cmdq, srrip_back.
//
//   channel   | handshake            | beat
//   ----------+----------------------+-----------------------------------------
//   request   | push / full          | req_type, set_index, way, addr, pc, hit
//   result    | pop / empty          | victim_way (victim requests only)
//   config    | psel/penable/pready  | bypass threshold at byte address 0
//
// The back part handles each item as one metadata RAM read of the set's row,
// then one write of the updated row; it takes no new item before that write.
// The front registers each item in its f1 stage ahead of the command queue.
// After reset a clearing pass writes every set row while full is held high.
// A victim result waits in the output register; a next victim waits until it drains.
module ship_rrip_stream_bypass_replacement #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int SIG_BITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                req_type_i,
  input  logic [srrip_pkg::SET_IDX_W-1:0]     set_index_i,
  input  logic [srrip_pkg::WAY_IDX_W-1:0]     way_i,
  input  logic [srrip_pkg::ADDR_W-1:0]        addr_i,
  input  logic [srrip_pkg::ADDR_W-1:0]        pc_i,
  input  logic                                hit_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [srrip_pkg::WAY_IDX_W-1:0]     victim_way_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [srrip_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [srrip_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [srrip_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  logic            busy, q_full, q_push, q_empty, q_pop, res_vld;
  srrip_pkg::cmd_t q_wdata, q_rdata;
  logic [1:0]      thr_q, thr_d;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == srrip_pkg::REG_STREAM_THR);
  assign thr_d  = cfg_wr ? pwdata[1:0] : thr_q;
  assign prdata = (paddr == srrip_pkg::REG_STREAM_THR) ?
                  srrip_pkg::CFG_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= srrip_pkg::THR_RESET;
    end else begin
      thr_q <= thr_d;
    end
  end

  srrip_front #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .SIG_BITS(SIG_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_type_i (req_type_i),
    .set_index_i(set_index_i),
    .way_i      (way_i),
    .addr_i     (addr_i),
    .pc_i       (pc_i),
    .hit_i      (hit_i),
    .busy_i     (busy),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  srrip_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  srrip_back #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS),
    .SIG_BITS(SIG_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .thr_i    (thr_q),
    .cmd_vld_i(!q_empty),
    .cmd_i    (q_rdata),
    .cmd_pop_o(q_pop),
    .busy_o   (busy),
    .res_vld_o(res_vld),
    .res_way_o(victim_way_o),
    .res_pop_i(pop && res_vld)
  );

  assign empty = !res_vld;

endmodule

// ===== rtl/srrip_chk.sv =====
// Port-level checker for the replacement block, bound to the top level.
// Depends on srrip_pkg and ship_rrip_stream_bypass_replacement_assert.svh.
`include "ship_rrip_stream_bypass_replacement_assert.svh"

module srrip_chk #(
  parameter int NUM_WAYS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                push,
  input logic                                full,
  input logic                                req_type_i,
  input logic [srrip_pkg::SET_IDX_W-1:0]     set_index_i,
  input logic [srrip_pkg::WAY_IDX_W-1:0]     way_i,
  input logic [srrip_pkg::ADDR_W-1:0]        addr_i,
  input logic [srrip_pkg::ADDR_W-1:0]        pc_i,
  input logic                                hit_i,
  input logic                                empty,
  input logic                                pop,
  input logic [srrip_pkg::WAY_IDX_W-1:0]     victim_way_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [srrip_pkg::CFG_ADDR_W-1:0]    paddr,
  input logic [srrip_pkg::CFG_DATA_W-1:0]    pwdata,
  input logic [srrip_pkg::CFG_DATA_W-1:0]    prdata,
  input logic                                pready
);

  `SRRIP_ASSERT(a_res_hold, clk_i, rst_ni, !empty && !pop |=> !empty, "result dropped before pop")
  `SRRIP_ASSERT(a_res_stable, clk_i, rst_ni, !empty && !pop |=> $stable(victim_way_o), "result changed while stalled")
  `SRRIP_ASSERT(a_way_range, clk_i, rst_ni, !empty |-> (32'(victim_way_o) < NUM_WAYS || NUM_WAYS > 16), "victim way out of range")
  `SRRIP_ASSERT(a_thr_readback, clk_i, rst_ni, psel && penable && pwrite && pready && paddr == srrip_pkg::REG_STREAM_THR |=> (paddr != srrip_pkg::REG_STREAM_THR || prdata[1:0] == $past(pwdata[1:0])), "threshold readback mismatch")
  `SRRIP_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready low")

endmodule

bind ship_rrip_stream_bypass_replacement srrip_chk #(.NUM_WAYS(NUM_WAYS)) u_chk (.*);
